[hdl/spectrum_peak_hold_meter_defines.svh]
// ----------------------------------------------------------------------------
// Spectrum peak hold meter assertion macros
// Shared concurrent assertion forms for the meter RTL.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_PEAK_HOLD_METER_DEFINES_SVH
`define SPECTRUM_PEAK_HOLD_METER_DEFINES_SVH

// same-cycle implication
`define SPM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/spm_pkg.sv]
// ----------------------------------------------------------------------------
// Spectrum peak hold meter package
// Constants, register indexes and sequencer states for the meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spm_pkg;

    localparam int NUM_BINS_DEF            = 126;
    localparam int PIXEL_FRACTION_BITS_DEF = 4;

    localparam int PIX_W    = 14;
    localparam int SLOT_W   = 7;
    localparam int HEIGHT_W = 10;
    localparam int MAG_W    = 16;
    localparam int SUM_W    = 23;
    localparam int ADDR_W   = 4;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BARS   = 2'd2;
    localparam logic [1:0] REG_PER    = 2'd3;

    localparam logic                RST_MODE   = 1'b1;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 10'd100;
    localparam logic [SLOT_W-1:0]   RST_BARS   = 7'd10;
    localparam logic [SLOT_W-1:0]   RST_PER    = 7'd12;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_C,
        ST_MUL_P,
        ST_ACCUM,
        ST_DIV,
        ST_ROOT1_INIT,
        ST_SQRT1,
        ST_ROOT2_INIT,
        ST_SQRT2,
        ST_SCALE,
        ST_LIMIT,
        ST_MOD,
        ST_PEAK_RD,
        ST_PEAK_WR,
        ST_OUT
    } t_state;

endpackage

[hdl/spectrum_peak_hold_meter.sv]
// A new input is taken only in idle, so each bin is through before the next is accepted.
// One shared subtract-compare unit runs 23 divide steps, then 32 + 16 root steps.
// Reset (i_rst_n low, synchronous): registers to defaults, frame restarted, then a
// pass over all NUM_BINS entries clears the peak memory; the same pass runs after a
// clear opcode and after a write that changes display_mode.
// ----------------------------------------------------------------------------
// Spectrum peak hold meter
// FFT bin levels through fourth root and height scaling, with decaying peaks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spectrum_peak_hold_meter_defines.svh"

module spectrum_peak_hold_meter #(
    parameter int NUM_BINS            = spm_pkg::NUM_BINS_DEF,
    parameter int PIXEL_FRACTION_BITS = spm_pkg::PIXEL_FRACTION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [spm_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_opcode,
    input  logic [spm_pkg::MAG_W-1:0]    i_current_magnitude,
    input  logic [spm_pkg::MAG_W-1:0]    i_previous_magnitude,
    input  logic [spm_pkg::MAG_W-1:0]    i_current_gain,
    input  logic [spm_pkg::MAG_W-1:0]    i_previous_gain,
    input  logic                         i_mix_enable,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [spm_pkg::SLOT_W-1:0]   o_slot_index,
    output logic [spm_pkg::PIX_W-1:0]    o_level,
    output logic [spm_pkg::PIX_W-1:0]    o_peak_level,
    output logic                         o_frame_last
);

    localparam int IDX_W = $clog2(NUM_BINS);
    localparam int POS_W = (IDX_W > spm_pkg::SLOT_W) ? IDX_W : spm_pkg::SLOT_W;
    localparam int PIX_W = spm_pkg::PIX_W;
    localparam int HW    = spm_pkg::HEIGHT_W;
    localparam int SW    = spm_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LAST_BIN  = IDX_W'(NUM_BINS - 1);
    localparam logic [POS_W-1:0] NBINS_POS = POS_W'(NUM_BINS);
    localparam logic [15:0]      FALL      = 16'(3 << (PIXEL_FRACTION_BITS - 1));
    localparam int               SCALE_SH  = 17 - PIXEL_FRACTION_BITS;

    spm_pkg::t_state r_state, n_state;

    logic              r_mode;
    logic [HW-1:0]     r_height;
    logic [SW-1:0]     r_bar_count;
    logic [SW-1:0]     r_bins_per_bar;

    logic [IDX_W-1:0]  r_bin_pos;
    logic [SW-1:0]     r_bar_pos;
    logic [22:0]       r_sum;
    logic [SW-1:0]     r_fill;
    logic [IDX_W-1:0]  r_clr_addr;

    logic [15:0]       r_cm, r_pm, r_cg, r_pg;
    logic              r_mix;

    logic [32:0]       r_acc;
    logic [63:0]       r_x;
    logic [32:0]       r_rem;
    logic [31:0]       r_root;
    logic [5:0]        r_cnt;
    logic [SW-1:0]     r_den;
    logic [POS_W-1:0]  r_slot;
    logic              r_last;
    logic [PIX_W-1:0]  r_level;
    logic [PIX_W-1:0]  r_peak_rd;
    logic [PIX_W-1:0]  r_peak;

    logic [PIX_W-1:0]  r_peak_mem [NUM_BINS];

    logic              r_o_valid;
    logic [SW-1:0]     r_o_slot;
    logic [PIX_W-1:0]  r_o_level;
    logic [PIX_W-1:0]  r_o_peak;
    logic              r_o_last;

    // configuration write decode
    logic              cfg_wr;
    logic              mode_change;
    logic              in_xfer;
    logic              out_free;
    logic              out_load;

    // shared subtract-compare unit
    logic [34:0]       alu_a, alu_b;
    logic [35:0]       alu_diff;
    logic              alu_ge;

    // shared multiplier
    logic [15:0]       mul_a, mul_b;
    logic [31:0]       mul_p;

    // frame step
    logic              last_bin;
    logic [15:0]       amp;
    logic [SW-1:0]     bars, per;
    logic [22:0]       sum_nx;
    logic [SW-1:0]     fill_nx;
    logic              close_bar;
    logic              emit;

    // scaling and peak
    logic [27:0]       lv3, lv, lim;
    logic [PIX_W-1:0]  pk_nx;

    // memory port
    logic              mem_we;
    logic [IDX_W-1:0]  mem_addr;
    logic [PIX_W-1:0]  mem_wdata;

    assign cfg_wr      = psel && penable && pwrite;
    assign mode_change = cfg_wr && (paddr[3:2] == spm_pkg::REG_MODE) && (pwdata[0] != r_mode);
    assign in_xfer     = i_valid && o_ready;
    assign out_free    = !r_o_valid || i_ready;
    assign out_load    = (r_state == spm_pkg::ST_OUT) && out_free;
    assign pready      = 1'b1;

    always_comb begin
        case (paddr[3:2])
            spm_pkg::REG_MODE:   prdata = {31'b0, r_mode};
            spm_pkg::REG_HEIGHT: prdata = {{(32 - HW){1'b0}}, r_height};
            spm_pkg::REG_BARS:   prdata = {{(32 - SW){1'b0}}, r_bar_count};
            spm_pkg::REG_PER:    prdata = {{(32 - SW){1'b0}}, r_bins_per_bar};
            default:             prdata = 32'b0;
        endcase
    end

    always_comb begin
        case (r_state)
            spm_pkg::ST_DIV: begin
                alu_a = {27'b0, r_rem[6:0], r_x[22]};
                alu_b = {28'b0, r_den};
            end
            spm_pkg::ST_SQRT1, spm_pkg::ST_SQRT2: begin
                alu_a = {r_rem, r_x[63:62]};
                alu_b = {1'b0, r_root, 2'b01};
            end
            default: begin
                alu_a = 35'b0;
                alu_b = 35'b0;
            end
        endcase
        alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
        alu_ge   = !alu_diff[35];
    end

    always_comb begin
        case (r_state)
            spm_pkg::ST_MUL_C: begin
                mul_a = r_cm;
                mul_b = r_cg;
            end
            spm_pkg::ST_MUL_P: begin
                mul_a = r_pm;
                mul_b = r_pg;
            end
            default: begin
                mul_a = r_root[15:0];
                mul_b = {{(16 - HW){1'b0}}, r_height};
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        last_bin  = (r_bin_pos == LAST_BIN);
        amp       = r_mix ? r_acc[32:17] : r_acc[31:16];
        bars      = (r_bar_count == '0) ? SW'(1) : r_bar_count;
        per       = (r_bins_per_bar == '0) ? SW'(1) : r_bins_per_bar;
        sum_nx    = r_sum + 23'(amp);
        fill_nx   = r_fill + SW'(1);
        close_bar = (fill_nx >= per) || last_bin;
        emit      = !r_mode || ((r_bar_pos < bars) && close_bar);
    end

    always_comb begin
        lv3   = {1'b0, r_acc[25:0], 1'b0} + {2'b0, r_acc[25:0]};
        lv    = lv3 >> SCALE_SH;
        lim   = 28'(r_height) << PIXEL_FRACTION_BITS;
        pk_nx = (({2'b0, r_level} + FALL) >= {2'b0, r_peak_rd}) ? r_level
                : r_peak_rd - PIX_W'(FALL);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spm_pkg::ST_CLEAR:      if (r_clr_addr == LAST_BIN) n_state = spm_pkg::ST_IDLE;
            spm_pkg::ST_IDLE:       if (in_xfer) begin
                n_state = i_opcode ? spm_pkg::ST_CLEAR : spm_pkg::ST_MUL_C;
            end
            spm_pkg::ST_MUL_C:      n_state = r_mix ? spm_pkg::ST_MUL_P : spm_pkg::ST_ACCUM;
            spm_pkg::ST_MUL_P:      n_state = spm_pkg::ST_ACCUM;
            spm_pkg::ST_ACCUM: begin
                if (!emit) begin
                    n_state = spm_pkg::ST_IDLE;
                end else if (!r_mode || fill_nx == SW'(1)) begin
                    n_state = spm_pkg::ST_ROOT1_INIT;
                end else begin
                    n_state = spm_pkg::ST_DIV;
                end
            end
            spm_pkg::ST_DIV:        if (r_cnt == 6'd22) n_state = spm_pkg::ST_ROOT1_INIT;
            spm_pkg::ST_ROOT1_INIT: n_state = spm_pkg::ST_SQRT1;
            spm_pkg::ST_SQRT1:      if (r_cnt == 6'd31) n_state = spm_pkg::ST_ROOT2_INIT;
            spm_pkg::ST_ROOT2_INIT: n_state = spm_pkg::ST_SQRT2;
            spm_pkg::ST_SQRT2:      if (r_cnt == 6'd15) n_state = spm_pkg::ST_SCALE;
            spm_pkg::ST_SCALE:      n_state = spm_pkg::ST_LIMIT;
            spm_pkg::ST_LIMIT:      n_state = spm_pkg::ST_MOD;
            spm_pkg::ST_MOD:        if (r_slot < NBINS_POS) n_state = spm_pkg::ST_PEAK_RD;
            spm_pkg::ST_PEAK_RD:    n_state = spm_pkg::ST_PEAK_WR;
            spm_pkg::ST_PEAK_WR:    n_state = spm_pkg::ST_OUT;
            spm_pkg::ST_OUT:        if (out_free) n_state = spm_pkg::ST_IDLE;
            default:                n_state = spm_pkg::ST_IDLE;
        endcase
        if (mode_change) begin
            n_state = spm_pkg::ST_CLEAR;
        end
    end

    // control outputs
    always_comb begin
        o_ready   = (r_state == spm_pkg::ST_IDLE);
        mem_we    = 1'b0;
        mem_addr  = r_slot[IDX_W-1:0];
        mem_wdata = pk_nx;
        case (r_state)
            spm_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_addr;
                mem_wdata = '0;
            end
            spm_pkg::ST_PEAK_WR: mem_we = 1'b1;
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_peak_mem[mem_addr] <= mem_wdata;
        end
        if (r_state == spm_pkg::ST_PEAK_RD) begin
            r_peak_rd <= r_peak_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
            r_o_slot  <= r_slot[SW-1:0];
            r_o_level <= r_level;
            r_o_peak  <= r_peak;
            r_o_last  <= r_last;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= spm_pkg::ST_CLEAR;
            r_mode         <= spm_pkg::RST_MODE;
            r_height       <= spm_pkg::RST_HEIGHT;
            r_bar_count    <= spm_pkg::RST_BARS;
            r_bins_per_bar <= spm_pkg::RST_PER;
            r_bin_pos      <= '0;
            r_bar_pos      <= '0;
            r_sum          <= '0;
            r_fill         <= '0;
            r_clr_addr     <= '0;
        end else begin
            r_state <= n_state;

            if (cfg_wr) begin
                case (paddr[3:2])
                    spm_pkg::REG_MODE:   r_mode         <= pwdata[0];
                    spm_pkg::REG_HEIGHT: r_height       <= pwdata[HW-1:0];
                    spm_pkg::REG_BARS:   r_bar_count    <= pwdata[SW-1:0];
                    spm_pkg::REG_PER:    r_bins_per_bar <= pwdata[SW-1:0];
                    default:             r_mode         <= r_mode;
                endcase
                r_bin_pos <= '0;
                r_bar_pos <= '0;
                r_sum     <= '0;
                r_fill    <= '0;
                if (mode_change) begin
                    r_clr_addr <= '0;
                end
            end else begin
                case (r_state)
                    spm_pkg::ST_CLEAR: r_clr_addr <= r_clr_addr + IDX_W'(1);
                    spm_pkg::ST_IDLE: begin
                        if (in_xfer) begin
                            r_cm     <= i_current_magnitude;
                            r_pm     <= i_previous_magnitude;
                            r_cg     <= i_current_gain;
                            r_pg     <= i_previous_gain;
                            r_mix    <= i_mix_enable;
                            if (i_opcode) begin
                                r_clr_addr <= '0;
                                r_bin_pos  <= '0;
                                r_bar_pos  <= '0;
                                r_sum      <= '0;
                                r_fill     <= '0;
                            end
                        end
                    end
                    spm_pkg::ST_MUL_C: r_acc <= {1'b0, mul_p};
                    spm_pkg::ST_MUL_P: r_acc <= r_acc + {1'b0, mul_p};
                    spm_pkg::ST_ACCUM: begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        if (!r_mode) begin
                            r_slot <= POS_W'(r_bin_pos);
                            r_x    <= {41'b0, 7'b0, amp};
                            r_den  <= SW'(1);
                            r_last <= last_bin;
                        end else if ((r_bar_pos < bars) && close_bar) begin
                            r_slot <= POS_W'(r_bar_pos);
                            r_x    <= {41'b0, sum_nx};
                            r_den  <= fill_nx;
                            r_last <= last_bin || ((r_bar_pos + SW'(1)) >= bars);
                        end
                        if (last_bin) begin
                            r_bin_pos <= '0;
                            r_bar_pos <= '0;
                            r_sum     <= '0;
                            r_fill    <= '0;
                        end else begin
                            r_bin_pos <= r_bin_pos + IDX_W'(1);
                            if (r_mode && (r_bar_pos < bars)) begin
                                if (close_bar) begin
                                    r_bar_pos <= r_bar_pos + SW'(1);
                                    r_sum     <= '0;
                                    r_fill    <= '0;
                                end else begin
                                    r_sum  <= sum_nx;
                                    r_fill <= fill_nx;
                                end
                            end
                        end
                    end
                    spm_pkg::ST_DIV: begin
                        r_rem      <= {26'b0, alu_ge ? alu_diff[6:0] : alu_a[6:0]};
                        r_x[22:0]  <= {r_x[21:0], alu_ge};
                        r_cnt      <= r_cnt + 6'd1;
                    end
                    spm_pkg::ST_ROOT1_INIT: begin
                        r_x    <= {r_x[15:0], 48'b0};
                        r_rem  <= '0;
                        r_root <= '0;
                        r_cnt  <= '0;
                    end
                    spm_pkg::ST_SQRT1, spm_pkg::ST_SQRT2: begin
                        r_rem  <= alu_ge ? alu_diff[32:0] : alu_a[32:0];
                        r_root <= {r_root[30:0], alu_ge};
                        r_x    <= {r_x[61:0], 2'b00};
                        r_cnt  <= r_cnt + 6'd1;
                    end
                    spm_pkg::ST_ROOT2_INIT: begin
                        r_x    <= {r_root, 32'b0};
                        r_rem  <= '0;
                        r_root <= '0;
                        r_cnt  <= '0;
                    end
                    spm_pkg::ST_SCALE: r_acc <= {1'b0, mul_p};
                    spm_pkg::ST_LIMIT: r_level <= (lv > lim) ? lim[PIX_W-1:0] : lv[PIX_W-1:0];
                    spm_pkg::ST_MOD: begin
                        if (r_slot >= NBINS_POS) begin
                            r_slot <= r_slot - NBINS_POS;
                        end
                    end
                    spm_pkg::ST_PEAK_WR: r_peak <= pk_nx;
                    default: r_clr_addr <= r_clr_addr;
                endcase
            end
        end
    end

    assign o_valid      = r_o_valid;
    assign o_slot_index = r_o_slot;
    assign o_level      = r_o_level;
    assign o_peak_level = r_o_peak;
    assign o_frame_last = r_o_last;

    `SPM_ASSERT_IMPL(a_slot_in_range, r_state == spm_pkg::ST_PEAK_RD, r_slot < NBINS_POS, "bad slot")
    `SPM_ASSERT_IMPL(a_div_nonzero, r_state == spm_pkg::ST_DIV, r_den != '0, "divide by zero")
    `SPM_ASSERT_NEXT(a_xfer_busy, in_xfer && !cfg_wr, r_state != spm_pkg::ST_IDLE, "idle after xfer")
    `SPM_ASSERT_IMPL(a_out_from_seq, $rose(r_o_valid), $past(r_state) == spm_pkg::ST_OUT, "stray result")

endmodule

[verif/spm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum peak hold meter checker
// Watches the register port and both transfer channels, predicts the bar or
// bin level and its decaying peak from the accepted bins, and compares each
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module spm_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [spm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    input  logic                       i_valid,
    input  logic                       o_ready,
    input  logic                       i_opcode,
    input  logic [15:0]                i_current_magnitude,
    input  logic [15:0]                i_previous_magnitude,
    input  logic [15:0]                i_current_gain,
    input  logic [15:0]                i_previous_gain,
    input  logic                       i_mix_enable,
    input  logic                       o_valid,
    input  logic                       i_ready,
    input  logic [6:0]                 o_slot_index,
    input  logic [13:0]                o_level,
    input  logic [13:0]                o_peak_level,
    input  logic                       o_frame_last,
    output int                         o_pending,
    output int                         o_fail_count
);

    localparam int BINS = spm_pkg::NUM_BINS_DEF;
    localparam int PFB  = spm_pkg::PIXEL_FRACTION_BITS_DEF;
    localparam int FALL = 3 << (PFB - 1);

    typedef struct packed {
        logic [6:0]  slot;
        logic [13:0] level;
        logic [13:0] peak;
        logic        last;
    } t_bar_result;

    t_bar_result expected_bars[$];

    logic        mode;
    logic [9:0]  height;
    logic [6:0]  bars;
    logic [6:0]  per_bar;
    logic [13:0] peak_mem[BINS];
    int unsigned bin_pos, bar_pos, fill;
    longint unsigned sum;
    int fails;

    assign o_pending    = expected_bars.size();
    assign o_fail_count = fails;

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] r, t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic logic [13:0] pixel_level(logic [15:0] amp);
        logic [63:0] root, lv, lim;
        root = isqrt(isqrt({amp, 48'd0}));
        lv   = (root * height * 3) >> (17 - PFB);
        lim  = 64'(height) << PFB;
        if (lv > lim) lv = lim;
        return lv[13:0];
    endfunction

    function automatic void restart();
        bin_pos = 0;
        bar_pos = 0;
        fill    = 0;
        sum     = 0;
    endfunction

    function automatic void clear_peaks();
        for (int k = 0; k < BINS; k++) peak_mem[k] = '0;
    endfunction

    function automatic void push_result(int unsigned slot, logic [15:0] amp, logic last);
        t_bar_result res;
        logic [13:0] lv, pk;
        int unsigned s;
        s  = slot % BINS;
        lv = pixel_level(amp);
        pk = peak_mem[s];
        if (32'(lv) + FALL >= 32'(pk)) pk = lv;
        else pk = 14'(32'(pk) - FALL);
        peak_mem[s] = pk;
        res.slot  = s[6:0];
        res.level = lv;
        res.peak  = pk;
        res.last  = last;
        expected_bars.push_back(res);
    endfunction

    function automatic void predict_bin();
        logic [63:0] amp;
        logic        last_bin;
        int unsigned nb, np;
        if (i_opcode) begin
            clear_peaks();
            restart();
            return;
        end
        if (i_mix_enable)
            amp = (64'(i_current_magnitude) * i_current_gain
                   + 64'(i_previous_magnitude) * i_previous_gain) >> 17;
        else
            amp = (64'(i_current_magnitude) * i_current_gain) >> 16;
        last_bin = (bin_pos >= BINS - 1);
        if (!mode) begin
            push_result(bin_pos, amp[15:0], last_bin);
        end else begin
            nb = (bars == 0) ? 1 : bars;
            np = (per_bar == 0) ? 1 : per_bar;
            if (bar_pos < nb) begin
                sum += amp;
                fill++;
                if (fill >= np || last_bin) begin
                    push_result(bar_pos, 16'(sum / fill), last_bin || (bar_pos + 1 >= nb));
                    bar_pos++;
                    sum  = 0;
                    fill = 0;
                end
            end
        end
        if (last_bin) restart();
        else bin_pos++;
    endfunction

    task automatic report(string what, int got, int want);
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        t_bar_result want;
        if (!i_rst_n) begin
            mode    = spm_pkg::RST_MODE;
            height  = spm_pkg::RST_HEIGHT;
            bars    = spm_pkg::RST_BARS;
            per_bar = spm_pkg::RST_PER;
            clear_peaks();
            restart();
            expected_bars.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    spm_pkg::REG_MODE: begin
                        if (pwdata[0] != mode) clear_peaks();
                        mode = pwdata[0];
                    end
                    spm_pkg::REG_HEIGHT: height  = pwdata[9:0];
                    spm_pkg::REG_BARS:   bars    = pwdata[6:0];
                    spm_pkg::REG_PER:    per_bar = pwdata[6:0];
                    default:             mode    = mode;
                endcase
                restart();
            end
            if (o_valid && i_ready) begin
                if (expected_bars.size() == 0) begin
                    report("unexpected result slot", o_slot_index, -1);
                end else begin
                    want = expected_bars.pop_front();
                    if (o_slot_index !== want.slot) report("slot", o_slot_index, want.slot);
                    if (o_level !== want.level) report("level", o_level, want.level);
                    if (o_peak_level !== want.peak) report("peak", o_peak_level, want.peak);
                    if (o_frame_last !== want.last) report("frame_last", o_frame_last, want.last);
                end
            end
            if (i_valid && o_ready) predict_bin();
        end
    end
endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum peak hold meter testbench
// Drives directed and random bins through several display settings with
// random idling on both channels, a long output hold-off and a drain pause;
// the checker predicts and compares, this top gives the verdict.
// ----------------------------------------------------------------------------

module testbench;

    localparam int LIMIT = 600000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 0;
    logic        o_ready;
    logic        i_opcode = 0;
    logic [15:0] i_current_magnitude = '0, i_previous_magnitude = '0;
    logic [15:0] i_current_gain = '0, i_previous_gain = '0;
    logic        i_mix_enable = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [6:0]  o_slot_index;
    logic [13:0] o_level, o_peak_level;
    logic        o_frame_last;
    int          pending, fail_count;
    int          cycles = 0;
    int          hold_req = 0, hold_seen = 0, hold_left = 0;
    bit          calm = 0;

    always #4 i_clk = ~i_clk;

    spectrum_peak_hold_meter u_dut (.*);

    spm_checker u_checker (
        .o_pending(pending), .o_fail_count(fail_count), .*
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("spectrum_peak_hold_meter verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            i_ready   <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 25);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel   <= 1;
        pwrite <= 1;
        paddr  <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_display(logic m, logic [9:0] h, logic [6:0] nb, logic [6:0] np);
        drain();
        reg_write(spm_pkg::REG_MODE, 32'(m));
        reg_write(spm_pkg::REG_HEIGHT, 32'(h));
        reg_write(spm_pkg::REG_BARS, 32'(nb));
        reg_write(spm_pkg::REG_PER, 32'(np));
    endtask

    task automatic send_bin(logic op, logic [15:0] cm, logic [15:0] pm,
                            logic [15:0] cg, logic [15:0] pg, logic mix);
        if (!calm && $urandom_range(99) < 25) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid              <= 1;
        i_opcode             <= op;
        i_current_magnitude  <= cm;
        i_previous_magnitude <= pm;
        i_current_gain       <= cg;
        i_previous_gain      <= pg;
        i_mix_enable         <= mix;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_bins(int n);
        repeat (n)
            send_bin($urandom_range(49) == 0, rand_word(), rand_word(),
                     rand_word(), rand_word(), 1'($urandom_range(1)));
        i_valid <= 0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_bin(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        send_bin(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        send_bin(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_bin(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1);
        send_bin(0, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 0);
        send_bin(0, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 1);
        send_bin(0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1);
        send_bin(0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
        for (int k = 0; k < 12; k++)
            send_bin(0, 16'hFFFF - 16'(k * 5000), 16'h1234, 16'hFFFF, 16'h00FF, k[0]);
        send_bin(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        send_bin(0, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 0);
        send_bin(1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        random_bins(60);

        set_display(0, 10'd1023, 7'd10, 7'd12);
        random_bins(130);

        set_display(1, 10'd1, 7'd126, 7'd1);
        random_bins(130);

        set_display(1, 10'd500, 7'd1, 7'd126);
        random_bins(70);
        drain();
        random_bins(60);

        set_display(1, 10'd0, 7'd0, 7'd0);
        random_bins(40);

        set_display(1, 10'd77, 7'd13, 7'd10);
        hold_req = 1;
        random_bins(130);

        set_display(0, 10'd100, 7'd10, 7'd12);
        calm = 1;
        random_bins(60);
        calm = 0;
        random_bins(40);

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("spectrum_peak_hold_meter verification clean");
        else
            $display("spectrum_peak_hold_meter verification failed");
        $finish;
    end
endmodule
